// ===== src/ubxp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ubxp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned KIND_W = 2;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd220;

   localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GOOD     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd2;

   // Control for the running checksum, driven by the frame sequencer.
   typedef struct packed {
      logic              clear;
      logic              add;
      logic              capture_a;
      logic [BYTE_W-1:0] data;
   } ubxp_sum_ctl_type;

endpackage

`default_nettype wire

// ===== src/ubxp_checksum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ubxp_checksum
   import ubxp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ubxp_sum_ctl_type ctl,
   output logic                  match
);

   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0] check_a_ff, check_a_in;

   always_comb begin
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      check_a_in = check_a_ff;
      if (ctl.clear) begin
         sum_a_in = '0;
         sum_b_in = '0;
      end else if (ctl.add) begin
         sum_a_in = sum_a_ff + ctl.data;
         sum_b_in = sum_b_ff + sum_a_in;
      end
      if (ctl.capture_a) begin
         check_a_in = ctl.data;
      end
   end

   // The byte on ctl.data is taken as the second check byte.
   assign match = (check_a_ff == sum_a_ff) && (ctl.data == sum_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff   <= '0;
         sum_b_ff   <= '0;
         check_a_ff <= '0;
      end else begin
         sum_a_ff   <= sum_a_in;
         sum_b_ff   <= sum_b_in;
         check_a_ff <= check_a_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/ubx_frame_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming parser for binary frames of the form B5 62 class id len_lo len_hi
// payload ck_a ck_b, fed one received byte per item. It takes one byte every
// cycle. The result a byte causes appears in the output register on the next
// cycle, set by the single sequencer step and the running Fletcher sums. While
// that result waits on a stalled receiver the input is stalled as well, so a
// new byte is taken only in a cycle where no result is held back. Each payload
// byte comes out with its index, and after the second check byte one frame-end
// item tells whether the checksum matched. Frames whose length exceeds the
// configured maximum are dropped without any item and the parser hunts for
// sync again.

module ubx_frame_parser_unit
   import ubxp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [LEN_W-1:0]  csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_byte_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [BYTE_W-1:0]      rsp_data_byte,
   output logic [LEN_W-1:0]       rsp_payload_index,
   output logic [BYTE_W-1:0]      rsp_msg_class,
   output logic [BYTE_W-1:0]      rsp_msg_id,
   output logic [LEN_W-1:0]       rsp_payload_length
);

   typedef enum logic [3:0] {
      PH_SYNC1   = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN_LO  = 4'd4,
      PH_LEN_HI  = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CK_A    = 4'd7,
      PH_CK_B    = 4'd8
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  max_len_ff;
   logic [BYTE_W-1:0] class_ff, class_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  count_ff, count_in;

   logic              out_valid_ff;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic [LEN_W-1:0]  out_index_ff, out_index_in;
   logic [BYTE_W-1:0] out_class_ff;
   logic [BYTE_W-1:0] out_id_ff;
   logic [LEN_W-1:0]  out_length_ff;

   logic              accept;
   logic              emit;
   logic [LEN_W-1:0]  len_full;
   logic [LEN_W-1:0]  count_next;
   logic              sum_match;
   ubxp_sum_ctl_type  sum_ctl;

   assign req_stall = out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign len_full  = {req_byte_in, length_ff[BYTE_W-1:0]};
   assign count_next = count_ff + LEN_W'(1);

   ubxp_checksum u_checksum (
      .clock (clock),
      .reset (reset),
      .ctl   (sum_ctl),
      .match (sum_match)
   );

   always_comb begin
      phase_in     = phase_ff;
      class_in     = class_ff;
      id_in        = id_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      emit         = 1'b0;
      out_kind_in  = KIND_PAYLOAD;
      out_data_in  = '0;
      out_index_in = '0;
      sum_ctl      = '{clear: 1'b0, add: 1'b0, capture_a: 1'b0, data: req_byte_in};
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               if (req_byte_in == SYNC_SECOND) begin
                  sum_ctl.clear = 1'b1;
                  phase_in      = PH_CLASS;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_CLASS: begin
               class_in    = req_byte_in;
               sum_ctl.add = 1'b1;
               phase_in    = PH_ID;
            end
            PH_ID: begin
               id_in       = req_byte_in;
               sum_ctl.add = 1'b1;
               phase_in    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in   = {{(LEN_W-BYTE_W){1'b0}}, req_byte_in};
               sum_ctl.add = 1'b1;
               phase_in    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in   = len_full;
               sum_ctl.add = 1'b1;
               count_in    = '0;
               // A zero length is accepted even when the maximum is zero.
               if (len_full == '0) begin
                  phase_in = PH_CK_A;
               end else if (len_full > max_len_ff) begin
                  phase_in = PH_SYNC1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               sum_ctl.add  = 1'b1;
               emit         = 1'b1;
               out_data_in  = req_byte_in;
               out_index_in = count_ff;
               count_in     = count_next;
               if (count_next >= length_ff) begin
                  phase_in = PH_CK_A;
               end
            end
            PH_CK_A: begin
               sum_ctl.capture_a = 1'b1;
               phase_in          = PH_CK_B;
            end
            PH_CK_B: begin
               emit        = 1'b1;
               out_kind_in = sum_match ? KIND_GOOD : KIND_MISMATCH;
               phase_in    = PH_SYNC1;
            end
            default: begin
               phase_in = (req_byte_in == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         max_len_ff   <= MAX_PAYLOAD_RESET;
         class_ff     <= '0;
         id_ff        <= '0;
         length_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // The result fields carry the frame header as it stood before this byte.
   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff   <= out_kind_in;
         out_data_ff   <= out_data_in;
         out_index_ff  <= out_index_in;
         out_class_ff  <= class_ff;
         out_id_ff     <= id_ff;
         out_length_ff <= length_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_data_byte      = out_data_ff;
   assign rsp_payload_index  = out_index_ff;
   assign rsp_msg_class      = out_class_ff;
   assign rsp_msg_id         = out_id_ff;
   assign rsp_payload_length = out_length_ff;

`ifndef NO_ASSERTIONS
   a_payload_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (count_ff < length_ff))
      else $error("payload count reached the declared length inside the payload");

   a_payload_item_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_PAYLOAD) |=> rsp_valid)
      else $error("accepted payload byte produced no item");

   a_frame_end_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_PAYLOAD) |->
         (rsp_data_byte == '0 && rsp_payload_index == '0))
      else $error("frame end item carries payload data");

   a_payload_index_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_PAYLOAD) |-> (rsp_payload_index < rsp_payload_length))
      else $error("payload index beyond declared length");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ubxp_pkg::*;

   typedef logic [BYTE_W-1:0] byte_q_t [$];

   typedef enum logic [3:0] {
      HUNT_SYNC1, HUNT_SYNC2, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
      GET_PAYLOAD, GET_CK_A, GET_CK_B
   } parse_phase_e;

   typedef enum int {FLAW_NONE, FLAW_CK_A, FLAW_CK_B, FLAW_CUT} frame_flaw_e;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  pos;
      logic [BYTE_W-1:0] cls;
      logic [BYTE_W-1:0] id;
      logic [LEN_W-1:0]  len;
   } parser_result_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [LEN_W-1:0]  csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_byte_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [BYTE_W-1:0] rsp_data_byte;
   logic [LEN_W-1:0]  rsp_payload_index;
   logic [BYTE_W-1:0] rsp_msg_class;
   logic [BYTE_W-1:0] rsp_msg_id;
   logic [LEN_W-1:0]  rsp_payload_length;

   ubx_frame_parser_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_msg_class      (rsp_msg_class),
      .rsp_msg_id         (rsp_msg_id),
      .rsp_payload_length (rsp_payload_length)
   );

   always #2 clock = ~clock;

   byte_q_t        rx_bytes_pending;
   parser_result_t parser_results_due [$];
   int             queued_total = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             mismatch_count = 0;
   int             bytes_taken = 0;
   int             payload_seen = 0;
   int             frames_good = 0;
   int             frames_bad = 0;
   int             frames_dropped = 0;

   // Shadow copy of the parser state and its length limit.
   parse_phase_e      phase_q = HUNT_SYNC1;
   logic [BYTE_W-1:0] cls_q = '0;
   logic [BYTE_W-1:0] id_q = '0;
   logic [LEN_W-1:0]  len_q = '0;
   logic [LEN_W-1:0]  count_q = '0;
   logic [BYTE_W-1:0] sum_a_q = '0;
   logic [BYTE_W-1:0] sum_b_q = '0;
   logic [BYTE_W-1:0] check_a_q = '0;
   logic [LEN_W-1:0]  size_limit = MAX_PAYLOAD_RESET;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) $display("ERROR at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic fold_sum(input logic [BYTE_W-1:0] b);
      sum_a_q = sum_a_q + b;
      sum_b_q = sum_b_q + sum_a_q;
   endtask

   task automatic predict_byte(input logic [BYTE_W-1:0] b);
      parser_result_t res;
      case (phase_q)
         HUNT_SYNC2: begin
            if (b == SYNC_SECOND) begin
               sum_a_q = '0;
               sum_b_q = '0;
               phase_q = GET_CLASS;
            end else begin
               phase_q = HUNT_SYNC1;
            end
         end
         GET_CLASS: begin
            cls_q = b;
            fold_sum(b);
            phase_q = GET_ID;
         end
         GET_ID: begin
            id_q = b;
            fold_sum(b);
            phase_q = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            len_q = {8'h00, b};
            fold_sum(b);
            phase_q = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            len_q[15:8] = b;
            fold_sum(b);
            count_q = '0;
            // A zero length wins over the limit, even when the limit is zero.
            if (len_q == '0) begin
               phase_q = GET_CK_A;
            end else if (len_q > size_limit) begin
               phase_q = HUNT_SYNC1;
               frames_dropped++;
            end else begin
               phase_q = GET_PAYLOAD;
            end
         end
         GET_PAYLOAD: begin
            fold_sum(b);
            res = '{KIND_PAYLOAD, b, count_q, cls_q, id_q, len_q};
            parser_results_due.push_back(res);
            payload_seen++;
            count_q = count_q + 1'b1;
            if (count_q >= len_q) phase_q = GET_CK_A;
         end
         GET_CK_A: begin
            check_a_q = b;
            phase_q = GET_CK_B;
         end
         GET_CK_B: begin
            if (check_a_q == sum_a_q && b == sum_b_q) begin
               res = '{KIND_GOOD, 8'h00, 16'h0000, cls_q, id_q, len_q};
               frames_good++;
            end else begin
               res = '{KIND_MISMATCH, 8'h00, 16'h0000, cls_q, id_q, len_q};
               frames_bad++;
            end
            parser_results_due.push_back(res);
            phase_q = HUNT_SYNC1;
         end
         default: begin
            phase_q = (b == SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_byte(req_byte_in);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (rx_bytes_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_byte_in <= rx_bytes_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      parser_result_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (parser_results_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected, kind %0d", rsp_kind));
            end else begin
               want = parser_results_due.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
               if (rsp_data_byte !== want.data)
                  report_mismatch($sformatf("data_byte %0h, expected %0h",
                                            rsp_data_byte, want.data));
               if (rsp_payload_index !== want.pos)
                  report_mismatch($sformatf("payload_index %0d, expected %0d",
                                            rsp_payload_index, want.pos));
               if (rsp_msg_class !== want.cls)
                  report_mismatch($sformatf("msg_class %0h, expected %0h",
                                            rsp_msg_class, want.cls));
               if (rsp_msg_id !== want.id)
                  report_mismatch($sformatf("msg_id %0h, expected %0h", rsp_msg_id, want.id));
               if (rsp_payload_length !== want.len)
                  report_mismatch($sformatf("payload_length %0d, expected %0d",
                                            rsp_payload_length, want.len));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic queue_byte(input logic [BYTE_W-1:0] b);
      rx_bytes_pending.push_back(b);
      queued_total++;
   endtask

   // Sync bytes are favored so that false starts and sync pairs inside frames are common.
   function automatic logic [BYTE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return SYNC_FIRST;
      if (r < 16) return SYNC_SECOND;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_length();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         v = $urandom_range(0, 10);
      end else if (r < 85) begin
         v = $urandom_range(11, 40);
      end else if (r < 93) begin
         if (size_limit > 300) begin
            v = $urandom_range(221, 300);
         end else begin
            v = int'(size_limit) + int'($urandom_range(0, 2)) - 1;
            if (v < 0) v = 0;
         end
      end else if (size_limit < 16'hFFFF) begin
         v = $urandom_range(int'(size_limit) + 1, 65535);
      end else begin
         v = $urandom_range(0, 10);
      end
      return v;
   endfunction

   task automatic queue_frame(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] id,
                              input logic [LEN_W-1:0] len, input byte_q_t body,
                              input frame_flaw_e flaw);
      logic [BYTE_W-1:0] sa;
      logic [BYTE_W-1:0] sb;
      logic [BYTE_W-1:0] hdr [4];
      int i;
      sa = '0;
      sb = '0;
      hdr[0] = cls;
      hdr[1] = id;
      hdr[2] = len[7:0];
      hdr[3] = len[15:8];
      queue_byte(SYNC_FIRST);
      queue_byte(SYNC_SECOND);
      for (i = 0; i < 4; i++) begin
         sa = sa + hdr[i];
         sb = sb + sa;
         queue_byte(hdr[i]);
      end
      for (i = 0; i < body.size(); i++) begin
         sa = sa + body[i];
         sb = sb + sa;
         queue_byte(body[i]);
      end
      if (flaw != FLAW_CUT) begin
         queue_byte(flaw == FLAW_CK_A ? sa ^ 8'($urandom_range(1, 255)) : sa);
         queue_byte(flaw == FLAW_CK_B ? sb ^ 8'($urandom_range(1, 255)) : sb);
      end
   endtask

   task automatic queue_random_stream(input int target);
      int stop;
      int r;
      int len;
      int nbody;
      int i;
      frame_flaw_e flaw;
      byte_q_t body;
      stop = queued_total + target;
      while (queued_total < stop) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            repeat ($urandom_range(1, 6)) queue_byte(pick_byte());
         end else if (r < 17) begin
            queue_byte(SYNC_FIRST);
            queue_byte(pick_byte());
         end else begin
            len = pick_length();
            r = $urandom_range(0, 99);
            if (r < 8) flaw = FLAW_CK_A;
            else if (r < 16) flaw = FLAW_CK_B;
            else if (r < 21) flaw = FLAW_CUT;
            else flaw = FLAW_NONE;
            nbody = len;
            // A dropped frame gets only a short tail, which the parser sees as noise.
            if (len > size_limit) nbody = $urandom_range(0, len < 10 ? len : 10);
            else if (flaw == FLAW_CUT) nbody = $urandom_range(0, len);
            body.delete();
            for (i = 0; i < nbody; i++) body.push_back(pick_byte());
            queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len),
                        body, flaw);
         end
      end
   endtask

   // Holds off until every item has gone in and every result has come out.
   task automatic wait_quiet();
      @(negedge clock);
      while (rx_bytes_pending.size() != 0 || req_valid || parser_results_due.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LEN_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_limit = value;
   endtask

   initial begin
      byte_q_t body;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 70;

      // The second B5 is not retried as a first sync byte, so the 62 is ignored.
      queue_byte(SYNC_FIRST);
      queue_byte(SYNC_FIRST);
      queue_byte(SYNC_SECOND);
      body.delete();
      queue_frame(8'hFF, 8'h00, 16'h0000, body, FLAW_NONE);
      body.push_back(SYNC_FIRST);
      body.push_back(SYNC_SECOND);
      queue_frame(8'h00, 8'hFF, 16'h0002, body, FLAW_CK_B);
      body.delete();
      queue_frame(8'h5A, 8'hA5, 16'hFFFF, body, FLAW_CUT);
      wait_quiet();

      // With a zero limit only zero-length frames get through.
      write_limit(16'h0000);
      queue_frame(8'h0A, 8'h04, 16'h0000, body, FLAW_NONE);
      body.push_back(8'h55);
      queue_frame(8'h0A, 8'h04, 16'h0001, body, FLAW_NONE);
      wait_quiet();

      write_limit(16'hFFFF);
      queue_random_stream(270);
      wait_quiet();
      queue_random_stream(270);
      wait_quiet();

      write_limit(16'd16);
      send_idle_pct = 70;
      recv_idle_pct = 23;
      queue_random_stream(270);
      wait_quiet();
      queue_random_stream(270);
      wait_quiet();

      write_limit(MAX_PAYLOAD_RESET);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_stream(270);
      wait_quiet();
      queue_random_stream(270);
      wait_quiet();

      $display("Fed %0d bytes; checked %0d payload bytes, %0d good and %0d bad frames.",
               bytes_taken, payload_seen, frames_good, frames_bad);
      $display("%0d oversize frames dropped under length limits 220, 0, 65535 and 16.",
               frames_dropped);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out waiting for the parser to drain.");
      $display("Mismatches found");
      $finish;
   end

endmodule
